// File: sv/ccdeg_pkg.sv
// ----------------------------------------------------------------------------
// ccdeg_pkg
// Shared types, widths and the fixed 3x3 event grade table.
// ----------------------------------------------------------------------------
package ccdeg_pkg;

  // Field widths.
  localparam int unsigned PhW    = 16;
  localparam int unsigned SumW   = 20;
  localparam int unsigned GradeW = 3;
  localparam int unsigned CountW = 4;
  localparam int unsigned RawW   = 4;
  localparam int unsigned NbrN   = 8;

  // Split threshold after reset.
  localparam logic signed [PhW-1:0] SplitThrReset = 16'sd40;

  // Raw table codes that need special handling, and the reported grade.
  localparam logic [RawW-1:0]   RAW_SQUARE   = 4'd6;
  localparam logic [RawW-1:0]   RAW_L_SHAPE  = 4'd8;
  localparam logic [GradeW-1:0] GRADE_L_OR_SQ = 3'd6;

  // Nine pulse heights: index 0 is the center, 1..8 the neighbours in
  // raster order (upper-left, upper, upper-right, left, right, lower-left,
  // lower, lower-right).
  typedef logic [8:0][PhW-1:0] ph_vec_t;

  // Classification result handed from the classifier to the summer.
  // Bit k of pattern is set when neighbour k+1 is at or above threshold.
  typedef struct packed {
    logic [NbrN-1:0]   pattern;
    logic              square;
    logic [GradeW-1:0] grade;
  } class_t;

  // Raw grade codes indexed by the 8-bit split pattern.
  localparam logic [RawW-1:0] GRADE_TABLE [256] = '{
    4'd0,4'd1,4'd2,4'd5,4'd1,4'd1,4'd5,4'd7,4'd3,4'd5,4'd8,4'd6,4'd3,4'd5,4'd7,4'd7,
    4'd4,4'd4,4'd8,4'd7,4'd5,4'd5,4'd6,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd1,4'd1,4'd2,4'd5,4'd1,4'd1,4'd5,4'd7,4'd5,4'd7,4'd7,4'd7,4'd5,4'd7,4'd7,4'd7,
    4'd4,4'd4,4'd8,4'd7,4'd5,4'd5,4'd6,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd2,4'd2,4'd7,4'd7,4'd2,4'd2,4'd7,4'd7,4'd8,4'd7,4'd7,4'd7,4'd8,4'd7,4'd7,4'd7,
    4'd8,4'd8,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd5,4'd5,4'd7,4'd7,4'd5,4'd5,4'd7,4'd7,4'd6,4'd7,4'd7,4'd7,4'd6,4'd7,4'd7,4'd7,
    4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd1,4'd1,4'd2,4'd5,4'd1,4'd1,4'd5,4'd7,4'd3,4'd5,4'd8,4'd6,4'd3,4'd5,4'd7,4'd7,
    4'd5,4'd5,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd1,4'd1,4'd2,4'd5,4'd1,4'd1,4'd5,4'd7,4'd5,4'd7,4'd7,4'd7,4'd5,4'd7,4'd7,4'd7,
    4'd5,4'd5,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd5,4'd5,4'd7,4'd7,4'd5,4'd5,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd6,4'd6,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,
    4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7,4'd7
  };

endpackage

// File: sv/ccdeg_classify.sv
// ----------------------------------------------------------------------------
// ccdeg_classify
// Compares the eight neighbours with the split threshold and looks up the
// event grade in the fixed table.
// ----------------------------------------------------------------------------
module ccdeg_classify (
  input  ccdeg_pkg::ph_vec_t               px_i,
  input  logic signed [ccdeg_pkg::PhW-1:0] thr_i,
  output ccdeg_pkg::class_t                cls_o
);
  import ccdeg_pkg::*;

  logic [NbrN-1:0] pattern;
  logic [RawW-1:0] raw;

  // One split bit per neighbour.
  always_comb begin
    for (int k = 0; k < NbrN; k++) begin
      pattern[k] = $signed(px_i[k+1]) >= thr_i;
    end
  end

  assign raw = GRADE_TABLE[pattern];

  // The L shape is reported with the square grade but adds no corners.
  always_comb begin
    cls_o.pattern = pattern;
    cls_o.square  = (raw == RAW_SQUARE);
    if (raw == RAW_L_SHAPE) begin
      cls_o.grade = GRADE_L_OR_SQ;
    end else begin
      cls_o.grade = raw[GradeW-1:0];
    end
  end

endmodule

// File: sv/ccdeg_sum.sv
// ----------------------------------------------------------------------------
// ccdeg_sum
// Selects the pixels that belong to the event and adds up their pulse
// heights and their count.
// ----------------------------------------------------------------------------
module ccdeg_sum (
  input  ccdeg_pkg::ph_vec_t                px_i,
  input  ccdeg_pkg::class_t                 cls_i,
  output logic signed [ccdeg_pkg::SumW-1:0] sum_o,
  output logic [ccdeg_pkg::CountW-1:0]      count_o
);
  import ccdeg_pkg::*;

  logic [NbrN-1:0]        p;
  logic [NbrN-1:0]        incl;
  logic signed [SumW-1:0] term [NbrN+1];

  assign p = cls_i.pattern;

  // Sides count whenever split; a corner only in a square event with both
  // adjacent sides split.
  always_comb begin
    incl    = '0;
    incl[1] = p[1];
    incl[3] = p[3];
    incl[4] = p[4];
    incl[6] = p[6];
    incl[0] = cls_i.square & p[0] & p[1] & p[3];
    incl[2] = cls_i.square & p[2] & p[1] & p[4];
    incl[5] = cls_i.square & p[5] & p[3] & p[6];
    incl[7] = cls_i.square & p[7] & p[4] & p[6];
  end

  // Masked sign-extended terms; the center is always included.
  always_comb begin
    term[0] = SumW'($signed(px_i[0]));
    for (int k = 0; k < NbrN; k++) begin
      term[k+1] = incl[k] ? SumW'($signed(px_i[k+1])) : '0;
    end
  end

  // Balanced adder tree over the nine terms.
  assign sum_o = ((term[0] + term[1]) + (term[2] + term[3])) +
                 ((term[4] + term[5]) + (term[6] + term[7])) + term[8];

  // Pixel count: the center plus every included neighbour.
  always_comb begin
    logic [CountW-1:0] cnt;
    cnt = CountW'(1);
    for (int k = 0; k < NbrN; k++) begin
      if (incl[k]) begin
        cnt = cnt + CountW'(1);
      end
    end
    count_o = cnt;
  end

endmodule

// File: sv/ccd_event_grade_classifier.sv
// ----------------------------------------------------------------------------
// ccd_event_grade_classifier
// 3x3 CCD event grading with summed pulse height and pixel count.
// ----------------------------------------------------------------------------
// One neighbourhood is taken in every clock cycle: busy is never asserted.
// The result is registered after the input register and appears on the
// cycle in which done_o is high, and is valid for that cycle only; the
// receiver cannot hold it off. The path runs through the input register
// and the result register, with the threshold compare, table lookup and
// nine-way adder in between. Write the split threshold only while no
// neighbourhood is in flight.
module ccd_event_grade_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 cfg_we_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     cfg_wdata_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     center_ph_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_upper_left_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_upper_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_upper_right_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_left_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_right_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_lower_left_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_lower_i,
  input  logic signed [ccdeg_pkg::PhW-1:0]     ph_lower_right_i,
  output logic                                 done_o,
  output logic [ccdeg_pkg::GradeW-1:0]         grade_o,
  output logic signed [ccdeg_pkg::SumW-1:0]    sum_ph_o,
  output logic [ccdeg_pkg::CountW-1:0]         pixel_count_o
);
  import ccdeg_pkg::*;

  logic signed [PhW-1:0]  thr_q;
  logic                   in_vld_q;
  ph_vec_t                px_q;
  ph_vec_t                px_d;
  class_t                 cls;
  logic signed [SumW-1:0] sum;
  logic [CountW-1:0]      cnt;
  logic                   accept;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Split threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= SplitThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Input register.
  assign px_d = {ph_lower_right_i, ph_lower_i, ph_lower_left_i, ph_right_i,
                 ph_left_i, ph_upper_right_i, ph_upper_i, ph_upper_left_i,
                 center_ph_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= px_d;
    end
  end

  ccdeg_classify u_classify (
    .px_i  (px_q),
    .thr_i (thr_q),
    .cls_o (cls)
  );

  ccdeg_sum u_sum (
    .px_i    (px_q),
    .cls_i   (cls),
    .sum_o   (sum),
    .count_o (cnt)
  );

  // Result register with its one-cycle strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      grade_o       <= cls.grade;
      sum_ph_o      <= sum;
      pixel_count_o <= cnt;
    end
  end

  // Every start transfer gives a result strobe on done_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("result strobe missing after start transfer");

  // The center is always counted and at most nine pixels are.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pixel_count_o >= CountW'(1)) && (pixel_count_o <= CountW'(9)))
    else $error("pixel count out of range");

  // Corners are added only in square events.
  a_corner_grade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (grade_o != GRADE_L_OR_SQ) |-> pixel_count_o <= CountW'(5))
    else $error("corner pixels counted outside a square event");

  // A single-pixel event counts the center alone.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (grade_o == GradeW'(0)) |-> pixel_count_o == CountW'(1))
    else $error("single event with extra pixels");

endmodule
